@@ sv/screen_reply_frame_parser_defines.svh @@
// Assertion macros shared by the frame parser RTL.
// Each macro takes a label, a clock, a reset, a condition and a consequence.
`ifndef SCREEN_REPLY_FRAME_PARSER_DEFINES_SVH
`define SCREEN_REPLY_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTH
`define SRFP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srfp assertion failed");
`define SRFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srfp assertion failed");
`else
`define SRFP_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SRFP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ sv/srfp_pkg.sv @@
package srfp_pkg;

   localparam logic [7:0] HEADER_FIRST   = 8'hA5;
   localparam logic [7:0] HEADER_SECOND  = 8'h5A;
   localparam logic [7:0] READ_REPLY_CMD = 8'h83;
   localparam logic [7:0] MAX_WORDS      = 8'd2;

   localparam int unsigned ADDR_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   localparam logic [ADDR_WIDTH-1:0] SWITCH_ADDRESS_RESET  = 16'h0030;
   localparam logic [ADDR_WIDTH-1:0] VOLTAGE_ADDRESS_RESET = 16'h0010;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SWITCH_ADDRESS  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VOLTAGE_ADDRESS = 1'b1;

   // Position within a reply frame; the data positions follow the word count.
   typedef enum logic [3:0] {
      POS_HEAD1   = 4'd0,
      POS_HEAD2   = 4'd1,
      POS_LENGTH  = 4'd2,
      POS_COMMAND = 4'd3,
      POS_ADDR_HI = 4'd4,
      POS_ADDR_LO = 4'd5,
      POS_COUNT   = 4'd6,
      POS_DATA0   = 4'd7,
      POS_DATA1   = 4'd8,
      POS_DATA2   = 4'd9,
      POS_DATA3   = 4'd10
   } pos_type;

endpackage

@@ sv/screen_reply_frame_parser.sv @@
// An accepted word waits in the input register, and its result word in the result register.
// Throughput: one word per cycle while the result side does not stall; the next parser state is combinational.
// The input register can still take one word while a result word waits.
// Reset (synchronous, active high) empties both registers, restarts the hunt for
// a header, clears the latched switch and voltage words and reloads the addresses.
`include "screen_reply_frame_parser_defines.svh"

module screen_reply_frame_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_frame_done,
   output logic                                 rsp_byte_rejected,
   output logic [srfp_pkg::ADDR_WIDTH-1:0]      rsp_frame_address,
   output logic [15:0]                          rsp_frame_value,
   output logic [15:0]                          rsp_switch_state,
   output logic [15:0]                          rsp_voltage_word,
   input  logic                                 csr_write_enable,
   input  logic [srfp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                          csr_wdata
);
   import srfp_pkg::*;

   // Input register: one received word waiting to be parsed.
   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  done_ff;
   logic                  rejected_ff;
   logic [ADDR_WIDTH-1:0] faddr_ff;
   logic [15:0]           fvalue_ff;

   // Parser state.
   pos_type               pos_ff, pos_in;
   logic [7:0]            len_ff, len_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [7:0]            hi_ff, hi_in;
   logic [7:0]            lo_ff, lo_in;
   logic [15:0]           switch_ff, switch_in;
   logic [15:0]           voltage_ff, voltage_in;

   // Configuration registers.
   logic [ADDR_WIDTH-1:0] sw_addr_ff;
   logic [ADDR_WIDTH-1:0] volt_addr_ff;

   logic                  out_free;
   logic                  advance;
   logic                  restart;
   logic                  complete;
   logic                  count_ok;
   logic                  more_bytes;
   logic [7:0]            hi_take;
   logic [7:0]            lo_take;
   logic [15:0]           word_now;

   // The result register can take a new word when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // The length byte must equal twice the word count plus four, with at most two words.
   assign count_ok = (({2'b00, in_byte_ff} << 1) + 10'd4 == {2'b00, len_ff})
                     && (in_byte_ff <= MAX_WORDS);

   // More data bytes remain while the position is below the length plus two.
   assign more_bytes = ({5'b00000, pos_ff} < ({1'b0, len_ff} + 9'd2));

   // The data bytes are taken before the end-of-frame check, so a frame with no words
   // still reports the byte after the count as its high byte, with a zero low byte.
   assign hi_take  = (pos_ff == POS_DATA0) ? in_byte_ff : hi_ff;
   assign lo_take  = (pos_ff == POS_DATA1) ? in_byte_ff : lo_ff;
   assign word_now = {hi_take, lo_take};

   // Next position, and whether this word breaks or finishes a frame.
   always_comb begin
      pos_in   = pos_ff;
      restart  = 1'b0;
      complete = 1'b0;
      unique case (pos_ff) inside
         POS_HEAD1: begin
            if (in_byte_ff == HEADER_FIRST) pos_in = POS_HEAD2;
            else restart = 1'b1;
         end
         POS_HEAD2: begin
            if (in_byte_ff == HEADER_SECOND) pos_in = POS_LENGTH;
            else restart = 1'b1;
         end
         POS_LENGTH: begin
            pos_in = POS_COMMAND;
         end
         POS_COMMAND: begin
            if (in_byte_ff == READ_REPLY_CMD) pos_in = POS_ADDR_HI;
            else restart = 1'b1;
         end
         POS_ADDR_HI: begin
            pos_in = POS_ADDR_LO;
         end
         POS_ADDR_LO: begin
            pos_in = POS_COUNT;
         end
         POS_COUNT: begin
            if (count_ok) pos_in = POS_DATA0;
            else restart = 1'b1;
         end
         POS_DATA0, POS_DATA1, POS_DATA2, POS_DATA3: begin
            if (more_bytes) pos_in = pos_type'(pos_ff + 4'd1);
            else complete = 1'b1;
         end
         default: begin
            restart = 1'b1;
         end
      endcase
      if (restart || complete) pos_in = POS_HEAD1;
   end

   // Frame fields and the latched words.
   always_comb begin
      len_in     = len_ff;
      addr_in    = addr_ff;
      hi_in      = hi_take;
      lo_in      = lo_take;
      switch_in  = switch_ff;
      voltage_in = voltage_ff;
      case (pos_ff)
         POS_LENGTH:  len_in  = in_byte_ff;
         POS_ADDR_HI: addr_in = {in_byte_ff, 8'h00};
         POS_ADDR_LO: addr_in = {addr_ff[15:8], in_byte_ff};
         default:     len_in  = len_ff;
      endcase
      // The voltage check sees the switch word as this frame leaves it.
      if (complete && (addr_ff == sw_addr_ff)) switch_in = word_now;
      if (complete && (addr_ff == volt_addr_ff) && (switch_in == 16'd1)) begin
         voltage_in = word_now;
      end
      if (restart || complete) begin
         len_in  = 8'h00;
         addr_in = '0;
         hi_in   = 8'h00;
         lo_in   = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= POS_HEAD1;
         len_ff       <= 8'h00;
         addr_ff      <= '0;
         hi_ff        <= 8'h00;
         lo_ff        <= 8'h00;
         switch_ff    <= 16'h0000;
         voltage_ff   <= 16'h0000;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (out_free) rsp_valid_ff <= in_valid_ff;
         if (advance) begin
            pos_ff     <= pos_in;
            len_ff     <= len_in;
            addr_ff    <= addr_in;
            hi_ff      <= hi_in;
            lo_ff      <= lo_in;
            switch_ff  <= switch_in;
            voltage_ff <= voltage_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_byte_ff <= req_rx_byte;
      if (advance) begin
         done_ff     <= complete;
         rejected_ff <= restart;
         faddr_ff    <= complete ? addr_ff : '0;
         fvalue_ff   <= complete ? word_now : 16'h0000;
      end
   end

   // Configuration writes must arrive only while the parser is idle; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_addr_ff   <= SWITCH_ADDRESS_RESET;
         volt_addr_ff <= VOLTAGE_ADDRESS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SWITCH_ADDRESS:  sw_addr_ff   <= csr_wdata;
            CSR_VOLTAGE_ADDRESS: volt_addr_ff <= csr_wdata;
            default:             sw_addr_ff   <= sw_addr_ff;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_done    = done_ff;
   assign rsp_byte_rejected = rejected_ff;
   assign rsp_frame_address = faddr_ff;
   assign rsp_frame_value   = fvalue_ff;
   // The latched words only change when a result word is loaded, so they stay
   // aligned with the result register.
   assign rsp_switch_state  = switch_ff;
   assign rsp_voltage_word  = voltage_ff;

   `SRFP_ASSERT_SAME(a_done_not_rejected, clock, reset, rsp_valid_ff, !(done_ff && rejected_ff))
   `SRFP_ASSERT_SAME(a_idle_fields_zero, clock, reset, rsp_valid_ff && !done_ff, (faddr_ff == '0) && (fvalue_ff == 16'h0000))
   `SRFP_ASSERT_SAME(a_data_length_legal, clock, reset, pos_ff >= POS_DATA0, (len_ff == 8'd4) || (len_ff == 8'd6) || (len_ff == 8'd8))
   `SRFP_ASSERT_NEXT(a_switch_holds, clock, reset, advance && !complete, $stable(switch_ff))
   `SRFP_ASSERT_NEXT(a_voltage_needs_switch, clock, reset, advance && (switch_in != 16'd1), $stable(voltage_ff))

endmodule

@@ tb/sv/tb_screen_reply_frame_parser.sv @@
module tb_screen_reply_frame_parser;

   import srfp_pkg::*;

   // One expected or observed result word of the parser.
   typedef struct packed {
      logic        done;
      logic        rejected;
      logic [15:0] address;
      logic [15:0] value;
      logic [15:0] switch_state;
      logic [15:0] voltage;
   } parse_outcome_type;

   // The scoreboard keeps its own copy of the parser state and of the two address
   // registers. Every accepted input word is run through it at once, and the
   // outcome waits in a queue until the matching result word comes out.
   class frame_parser_scoreboard;
      pos_type           position;
      logic [7:0]        frame_len;
      logic [15:0]       addr_field;
      logic [7:0]        data_hi;
      logic [7:0]        data_lo;
      logic [15:0]       switch_latch;
      logic [15:0]       voltage_latch;
      logic [15:0]       switch_addr;
      logic [15:0]       voltage_addr;
      parse_outcome_type expected_outcomes[$];
      int                mismatches;
      int                frames_completed;
      int                bytes_rejected;
      int                voltage_updates;

      function new();
         switch_addr = SWITCH_ADDRESS_RESET;
         voltage_addr = VOLTAGE_ADDRESS_RESET;
         switch_latch = '0;
         voltage_latch = '0;
         mismatches = 0;
         frames_completed = 0;
         bytes_rejected = 0;
         voltage_updates = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         position = POS_HEAD1;
         frame_len = '0;
         addr_field = '0;
         data_hi = '0;
         data_lo = '0;
      endfunction

      function void set_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [15:0] data);
         case (idx)
            CSR_SWITCH_ADDRESS: switch_addr = data;
            CSR_VOLTAGE_ADDRESS: voltage_addr = data;
            default: ;
         endcase
      endfunction

      // Advances the copy of the parser by one received byte.
      function void parse_byte(input logic [7:0] rx);
         parse_outcome_type o;
         logic restart;
         o = '0;
         restart = 1'b0;
         case (position)
            POS_HEAD1: begin
               if (rx == HEADER_FIRST) position = POS_HEAD2;
               else restart = 1'b1;
            end
            POS_HEAD2: begin
               if (rx == HEADER_SECOND) position = POS_LENGTH;
               else restart = 1'b1;
            end
            POS_LENGTH: begin
               frame_len = rx;
               position = POS_COMMAND;
            end
            POS_COMMAND: begin
               if (rx == READ_REPLY_CMD) position = POS_ADDR_HI;
               else restart = 1'b1;
            end
            POS_ADDR_HI: begin
               addr_field = {rx, 8'h00};
               position = POS_ADDR_LO;
            end
            POS_ADDR_LO: begin
               addr_field[7:0] = rx;
               position = POS_COUNT;
            end
            POS_COUNT: begin
               // The length must agree with the word count, and at most two words.
               if ((int'(rx) * 2 + 4) == int'(frame_len) && rx <= MAX_WORDS)
                  position = POS_DATA0;
               else
                  restart = 1'b1;
            end
            default: begin
               if (position == POS_DATA0) data_hi = rx;
               else if (position == POS_DATA1) data_lo = rx;
               if (int'(position) < int'(frame_len) + 2) begin
                  position = pos_type'(position + 4'd1);
               end else begin
                  // Last byte of the frame: report it and update the latches.
                  // The switch word goes first, so the voltage test sees it.
                  o.done = 1'b1;
                  o.address = addr_field;
                  o.value = {data_hi, data_lo};
                  if (addr_field == switch_addr) switch_latch = o.value;
                  if (addr_field == voltage_addr && switch_latch == 16'd1) begin
                     voltage_latch = o.value;
                     voltage_updates++;
                  end
                  frames_completed++;
                  clear_frame();
               end
            end
         endcase
         if (restart) begin
            clear_frame();
            o.rejected = 1'b1;
            bytes_rejected++;
         end
         o.switch_state = switch_latch;
         o.voltage = voltage_latch;
         expected_outcomes.push_back(o);
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction

      task report(input string msg);
         if (mismatches < 30) $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_outcome(input parse_outcome_type got);
         parse_outcome_type want;
         if (expected_outcomes.size() == 0) begin
            report("result word arrived with no input word outstanding");
         end else begin
            want = expected_outcomes.pop_front();
            if (got.done !== want.done)
               report($sformatf("frame_done %b, expected %b", got.done, want.done));
            if (got.rejected !== want.rejected)
               report($sformatf("byte_rejected %b, expected %b",
                                got.rejected, want.rejected));
            if (got.address !== want.address)
               report($sformatf("frame_address %h, expected %h",
                                got.address, want.address));
            if (got.value !== want.value)
               report($sformatf("frame_value %h, expected %h", got.value, want.value));
            if (got.switch_state !== want.switch_state)
               report($sformatf("switch_state %h, expected %h",
                                got.switch_state, want.switch_state));
            if (got.voltage !== want.voltage)
               report($sformatf("voltage_word %h, expected %h",
                                got.voltage, want.voltage));
         end
      endtask

      task flag_leftovers();
         if (expected_outcomes.size() != 0)
            report($sformatf("%0d result words never arrived", expected_outcomes.size()));
      endtask
   endclass

   // Every input of the block holds a known value from time zero.
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_rx_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_frame_done;
   logic                       rsp_byte_rejected;
   logic [ADDR_WIDTH-1:0]      rsp_frame_address;
   logic [15:0]                rsp_frame_value;
   logic [15:0]                rsp_switch_state;
   logic [15:0]                rsp_voltage_word;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [15:0]                csr_wdata = '0;

   frame_parser_scoreboard sb = new();

   // While set, neither side inserts gaps or stalls of its own.
   bit steady_flow = 1'b0;
   int bytes_sent = 0;

   screen_reply_frame_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_byte_rejected (rsp_byte_rejected),
      .rsp_frame_address (rsp_frame_address),
      .rsp_frame_value   (rsp_frame_value),
      .rsp_switch_state  (rsp_switch_state),
      .rsp_voltage_word  (rsp_voltage_word),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A generous ceiling on the whole run; a correct run ends far sooner.
   initial begin
      #4000000;
      $display("Timed out waiting for the parser");
      $display("Test completed with failures");
      $finish;
   end

   // Gap lengths: mostly none, sometimes short, now and then a long pause.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Result side. Outputs are sampled at the clock edge, before the block's own
   // updates of that edge land, so each word is seen exactly as it was accepted.
   // After the 300th and the 700th result the receiver holds off for a long
   // stretch whilst the sender keeps offering words, so that the block fills up
   // and has to stall its input.
   initial begin : result_sink
      int hold_left;
      int stall_left;
      int results_seen;
      hold_left = 0;
      stall_left = 0;
      results_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_outcome({rsp_frame_done, rsp_byte_rejected, rsp_frame_address,
                              rsp_frame_value, rsp_switch_state, rsp_voltage_word});
            results_seen++;
            if (results_seen == 300 || results_seen == 700) hold_left = 120;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = idle_length();
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Offers one word and waits for it to be taken. Valid stays high into the next
   // word when no gap follows, so it is never lowered and raised in one step.
   task automatic send_byte(input logic [7:0] rx);
      int gap;
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.parse_byte(rx);
      bytes_sent++;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lowers valid and waits until every result word is back. Each input word
   // gives exactly one result, so an empty queue leaves the block idle.
   task automatic settle();
      int cap;
      cap = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 && cap < 5000) begin
         @(posedge clock);
         cap++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] sw_addr, input logic [15:0] volt_addr);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SWITCH_ADDRESS;
      csr_wdata <= sw_addr;
      @(posedge clock);
      csr_index <= CSR_VOLTAGE_ADDRESS;
      csr_wdata <= volt_addr;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_register(CSR_SWITCH_ADDRESS, sw_addr);
      sb.set_register(CSR_VOLTAGE_ADDRESS, volt_addr);
   endtask

   // Frames mostly aim at the two live addresses so that the latches move often.
   function automatic logic [15:0] pick_address();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return sb.switch_addr;
      if (r < 65) return sb.voltage_addr;
      if (r < 70) return 16'h0000;
      if (r < 75) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // One random sequence: most are well-formed frames with random content, the
   // rest are line noise, frames broken at one of the checks, or frames cut short.
   task automatic send_random_sequence();
      logic [7:0]  seq[$];
      logic [15:0] addr;
      logic [15:0] val;
      logic [7:0]  b;
      int          kind;
      int          count;
      int          keep;
      int          r;
      kind = $urandom_range(0, 99);
      count = $urandom_range(0, 2);
      addr = pick_address();
      r = $urandom_range(0, 9);
      if (addr == sb.switch_addr && r < 5) val = 16'd1;
      else if (r == 5) val = 16'h0000;
      else if (r == 6) val = 16'hFFFF;
      else val = 16'($urandom);
      seq = {HEADER_FIRST, HEADER_SECOND, 8'(count * 2 + 4), READ_REPLY_CMD,
             addr[15:8], addr[7:0], 8'(count)};
      // A zero-count frame still takes one byte as the high data byte.
      seq.push_back(val[15:8]);
      if (count > 0) seq.push_back(val[7:0]);
      if (count == 2) begin
         seq.push_back(8'($urandom));
         seq.push_back(8'($urandom));
      end
      keep = seq.size();
      if (kind < 12) begin
         seq.delete();
         repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom));
         keep = seq.size();
      end else if (kind < 32) begin
         case ($urandom_range(0, 4))
            0: begin
               do b = 8'($urandom); while (b == HEADER_SECOND);
               seq[1] = b;
               keep = 2;
            end
            1: begin
               do b = 8'($urandom); while (b == READ_REPLY_CMD);
               seq[3] = b;
               keep = 4;
            end
            2: begin
               do b = 8'($urandom); while (b == seq[2]);
               seq[2] = b;
               keep = 7;
            end
            3: begin
               // Too many words, with a length that agrees modulo 256.
               b = 8'($urandom_range(3, 255));
               seq[6] = b;
               seq[2] = 8'(b * 2 + 4);
               keep = 7;
            end
            default: keep = $urandom_range(1, seq.size() - 1);
         endcase
      end
      while (seq.size() > keep) void'(seq.pop_back());
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   task automatic random_phase(input int words);
      int target;
      target = bytes_sent + words;
      while (bytes_sent < target) send_random_sequence();
   endtask

   initial begin : stimulus
      logic [7:0] directed[$];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset addresses: a stray byte, a bad second
      // header made of all ones, a one-word frame that sets the switch state to
      // one, then a two-word voltage frame with an all-ones first word that is
      // therefore taken.
      directed = {8'h00, HEADER_FIRST, 8'hFF,
                  HEADER_FIRST, HEADER_SECOND, 8'h06, READ_REPLY_CMD, 8'h00, 8'h30,
                  8'h01, 8'h00, 8'h01,
                  HEADER_FIRST, HEADER_SECOND, 8'h08, READ_REPLY_CMD, 8'h00, 8'h10,
                  8'h02, 8'hFF, 8'hFF, 8'h12, 8'h34};
      foreach (directed[i]) send_byte(directed[i]);
      random_phase(180);

      // Address settings, among them both extremes and the case of one address
      // serving both latches. One phase runs with no gaps or stalls at all.
      settle();
      configure(16'h0000, 16'hFFFF);
      random_phase(210);
      settle();
      configure(16'hFFFF, 16'h0000);
      steady_flow = 1'b1;
      random_phase(210);
      steady_flow = 1'b0;
      settle();
      configure(16'h1234, 16'h1234);
      random_phase(210);
      settle();
      configure(16'($urandom), 16'($urandom));
      random_phase(210);

      settle();
      sb.flag_leftovers();
      $display("Sent %0d words over 5 address settings; %0d frames completed,",
               bytes_sent, sb.frames_completed);
      $display("%0d bytes rejected, %0d voltage updates, %0d mismatches.",
               sb.bytes_rejected, sb.voltage_updates, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
